// ===== src/tlr_pkg.sv =====
// Shared types and constants of the thick line rasteriser.
package tlr_pkg;

   localparam int COORD_W = 6;
   localparam int THICK_W = 4;
   localparam int REG_W   = 7;
   localparam int DEC_W   = 16;
   localparam int EAST_W  = 8;
   localparam int DIAG_W  = 9;

   localparam logic REG_GRID_COLUMNS = 1'b0;
   localparam logic REG_GRID_ROWS    = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] span_low;
      logic [COORD_W-1:0] span_high;
      logic               visible;
   } span_result_type;

endpackage

// ===== src/tlr_span.sv =====
// Vertical span of one column, clipped to the grid, with its visibility.
module tlr_span (
   input  logic [tlr_pkg::COORD_W-1:0] x,
   input  logic [tlr_pkg::COORD_W-1:0] y,
   input  logic [tlr_pkg::THICK_W-1:0] thickness,
   input  logic [tlr_pkg::REG_W-1:0]   cols,
   input  logic [tlr_pkg::REG_W-1:0]   rows,
   output tlr_pkg::span_result_type    span
);
   import tlr_pkg::*;

   logic [THICK_W-1:0]    reach;
   logic signed [7:0]     lo_full;
   logic [REG_W-1:0]      hi_full;
   logic [REG_W-1:0]      rows_top;
   logic [COORD_W-1:0]    lo;
   logic [COORD_W-1:0]    hi;
   logic                  rows_zero;

   always_comb begin
      reach     = thickness - THICK_W'(1);
      lo_full   = $signed({2'b00, y}) - $signed({4'b0000, reach});
      hi_full   = {1'b0, y} + {3'b000, reach};
      rows_top  = rows - REG_W'(1);
      rows_zero = (rows == '0);
      lo        = lo_full[7] ? '0 : lo_full[COORD_W-1:0];
      if (rows_zero) begin
         hi = '0;
      end else if (hi_full > rows_top) begin
         hi = rows_top[COORD_W-1:0];
      end else begin
         hi = hi_full[COORD_W-1:0];
      end
      span.span_low  = lo;
      span.span_high = hi;
      span.visible   = !rows_zero && ({1'b0, x} < cols) && (lo <= hi);
   end

endmodule

// ===== src/thick_line_rasterizer_unit.sv =====
// Top level of the thick line rasteriser: sequencer, shared decision adder and register port.
// A request is taken in the idle state, the slope terms are set up in the setup state, and the
// first column is registered at the output from the run state once the output is free.
// A segment of N columns (N = right x - left x + 1, at most GRID_MAX) keeps the block busy with
// no new request taken; the single decision adder advances one column per cycle unless stalled.
// Synchronous active-high reset clears the sequencer and sets both grid registers to 16.
module thick_line_rasterizer_unit #(
   parameter int GRID_MAX = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [tlr_pkg::COORD_W-1:0] req_first_x,
   input  logic [tlr_pkg::COORD_W-1:0] req_first_y,
   input  logic [tlr_pkg::COORD_W-1:0] req_second_x,
   input  logic [tlr_pkg::COORD_W-1:0] req_second_y,
   input  logic [tlr_pkg::THICK_W-1:0] req_thickness,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tlr_pkg::COORD_W-1:0] rsp_column,
   output logic [tlr_pkg::COORD_W-1:0] rsp_centre_row,
   output logic [tlr_pkg::COORD_W-1:0] rsp_span_low,
   output logic [tlr_pkg::COORD_W-1:0] rsp_span_high,
   output logic                        rsp_visible,
   output logic                        rsp_last_column,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [2:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import tlr_pkg::*;

   localparam int CNT_W = $clog2(GRID_MAX + 1);

   state_type state_ff, state_in;

   logic [REG_W-1:0] grid_columns_ff, grid_columns_in;
   logic [REG_W-1:0] grid_rows_ff, grid_rows_in;

   logic [COORD_W-1:0]       cur_x_ff, cur_x_in;
   logic [COORD_W-1:0]       cur_y_ff, cur_y_in;
   logic [COORD_W-1:0]       end_x_ff, end_x_in;
   logic [COORD_W-1:0]       end_y_ff, end_y_in;
   logic signed [DEC_W-1:0]  decision_ff, decision_in;
   logic signed [EAST_W-1:0] step_east_ff, step_east_in;
   logic signed [DIAG_W-1:0] step_diagonal_ff, step_diagonal_in;
   logic                     slope_negative_ff, slope_negative_in;
   logic [THICK_W-1:0]       held_thickness_ff, held_thickness_in;
   logic [CNT_W-1:0]         count_ff, count_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COORD_W-1:0]       column_ff, centre_row_ff;
   span_result_type          span_ff;
   logic                     last_column_ff;

   logic                     req_take;
   logic                     out_free;
   logic                     load_out;
   logic                     seg_done;
   logic                     at_end;
   logic                     csr_write;

   logic                     swap;
   logic [COORD_W:0]         dx;
   logic signed [7:0]        dy;
   logic                     neg;
   logic signed [DIAG_W-1:0] de;
   logic signed [DIAG_W-1:0] dx2;
   logic                     diag;
   logic signed [7:0]        y_step;

   logic signed [DEC_W-1:0]  add_a, add_b, add_sum;

   logic [REG_W-1:0]         cols_sat, rows_sat;
   span_result_type          span_now;

   // ------------------------------------------------------------------ register port
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      grid_columns_in = grid_columns_ff;
      grid_rows_in    = grid_rows_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_GRID_COLUMNS: grid_columns_in = pwdata[REG_W-1:0];
            REG_GRID_ROWS:    grid_rows_in    = pwdata[REG_W-1:0];
            default:          grid_columns_in = grid_columns_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_GRID_COLUMNS: prdata = {{(32-REG_W){1'b0}}, grid_columns_ff};
         REG_GRID_ROWS:    prdata = {{(32-REG_W){1'b0}}, grid_rows_ff};
         default:          prdata = '0;
      endcase
   end

   assign cols_sat = (grid_columns_ff > REG_W'(GRID_MAX)) ? REG_W'(GRID_MAX) : grid_columns_ff;
   assign rows_sat = (grid_rows_ff > REG_W'(GRID_MAX)) ? REG_W'(GRID_MAX) : grid_rows_ff;

   // ------------------------------------------------------------------ datapath terms
   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign swap     = req_first_x > req_second_x;

   always_comb begin
      dx   = {1'b0, end_x_ff} - {1'b0, cur_x_ff};
      dy   = $signed({2'b00, end_y_ff}) - $signed({2'b00, cur_y_ff});
      neg  = (dx != '0) && dy[7];
      de   = DIAG_W'(dy) <<< 1;
      dx2  = $signed({1'b0, dx, 1'b0});
      // A rising slope steps diagonally only on a strictly positive decision.
      diag = slope_negative_ff ? decision_ff[DEC_W-1]
                               : (!decision_ff[DEC_W-1] && (decision_ff != '0));
   end

   // One adder serves both the initial decision and every column step.
   always_comb begin
      if (state_ff == ST_SETUP) begin
         add_a = DEC_W'(de);
         add_b = neg ? DEC_W'($signed({1'b0, dx})) : -DEC_W'($signed({1'b0, dx}));
      end else begin
         add_a = decision_ff;
         add_b = diag ? DEC_W'(step_diagonal_ff) : DEC_W'(step_east_ff);
      end
      add_sum = add_a + add_b;
   end

   always_comb begin
      if (!diag) begin
         y_step = $signed({2'b00, cur_y_ff});
      end else if (slope_negative_ff) begin
         y_step = $signed({2'b00, cur_y_ff}) - 8'sd1;
      end else begin
         y_step = $signed({2'b00, cur_y_ff}) + 8'sd1;
      end
   end

   assign at_end   = (cur_x_ff >= end_x_ff);
   assign seg_done = at_end || (count_ff == CNT_W'(GRID_MAX - 1));

   tlr_span u_span (
      .x         (cur_x_ff),
      .y         (cur_y_ff),
      .thickness (held_thickness_ff),
      .cols      (cols_sat),
      .rows      (rows_sat),
      .span      (span_now)
   );

   // ------------------------------------------------------------------ sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_SETUP;
         ST_SETUP: state_in = ST_RUN;
         ST_RUN:   if (out_free && seg_done) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE:  req_stall = 1'b0;
         ST_SETUP: req_stall = 1'b1;
         ST_RUN:   load_out  = out_free;
         default:  req_stall = 1'b1;
      endcase
   end

   always_comb begin
      cur_x_in          = cur_x_ff;
      cur_y_in          = cur_y_ff;
      end_x_in          = end_x_ff;
      end_y_in          = end_y_ff;
      decision_in       = decision_ff;
      step_east_in      = step_east_ff;
      step_diagonal_in  = step_diagonal_ff;
      slope_negative_in = slope_negative_ff;
      held_thickness_in = held_thickness_ff;
      count_in          = count_ff;
      if (req_take) begin
         cur_x_in          = swap ? req_second_x : req_first_x;
         cur_y_in          = swap ? req_second_y : req_first_y;
         end_x_in          = swap ? req_first_x : req_second_x;
         end_y_in          = swap ? req_first_y : req_second_y;
         held_thickness_in = (req_thickness == '0) ? THICK_W'(1) : req_thickness;
         count_in          = '0;
      end else if (state_ff == ST_SETUP) begin
         slope_negative_in = neg;
         step_east_in      = de[EAST_W-1:0];
         step_diagonal_in  = neg ? (de + dx2) : (de - dx2);
         decision_in       = add_sum;
      end else if (load_out && !seg_done) begin
         decision_in = add_sum;
         cur_x_in    = cur_x_ff + COORD_W'(1);
         count_in    = count_ff + CNT_W'(1);
         if (y_step[7]) begin
            cur_y_in = '0;
         end else if (y_step > 8'sd63) begin
            cur_y_in = '1;
         end else begin
            cur_y_in = y_step[COORD_W-1:0];
         end
      end
   end

   assign rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         rsp_valid_ff      <= 1'b0;
         grid_columns_ff   <= REG_W'(16);
         grid_rows_ff      <= REG_W'(16);
         cur_x_ff          <= '0;
         cur_y_ff          <= '0;
         end_x_ff          <= '0;
         end_y_ff          <= '0;
         decision_ff       <= '0;
         step_east_ff      <= '0;
         step_diagonal_ff  <= '0;
         slope_negative_ff <= 1'b0;
         held_thickness_ff <= THICK_W'(1);
         count_ff          <= '0;
      end else begin
         state_ff          <= state_in;
         rsp_valid_ff      <= rsp_valid_in;
         grid_columns_ff   <= grid_columns_in;
         grid_rows_ff      <= grid_rows_in;
         cur_x_ff          <= cur_x_in;
         cur_y_ff          <= cur_y_in;
         end_x_ff          <= end_x_in;
         end_y_ff          <= end_y_in;
         decision_ff       <= decision_in;
         step_east_ff      <= step_east_in;
         step_diagonal_ff  <= step_diagonal_in;
         slope_negative_ff <= slope_negative_in;
         held_thickness_ff <= held_thickness_in;
         count_ff          <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         column_ff      <= cur_x_ff;
         centre_row_ff  <= cur_y_ff;
         span_ff        <= span_now;
         last_column_ff <= at_end;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_column      = column_ff;
   assign rsp_centre_row  = centre_row_ff;
   assign rsp_span_low    = span_ff.span_low;
   assign rsp_span_high   = span_ff.span_high;
   assign rsp_visible     = span_ff.visible;
   assign rsp_last_column = last_column_ff;

   // ------------------------------------------------------------------ checks
   a_take_to_setup: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_SETUP)
      else $error("accepted request did not start the setup step");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> count_ff < CNT_W'(GRID_MAX))
      else $error("column count ran past the grid limit");

   a_x_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> cur_x_ff <= end_x_ff)
      else $error("current column passed the right endpoint");

   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      (load_out && seg_done) |=> state_ff == ST_IDLE && rsp_valid_ff)
      else $error("final column did not return the sequencer to idle");

endmodule

// ===== tb/tb_thick_line_rasterizer_unit.sv =====
// Self-checking testbench for the thick line rasteriser: segment requests in, column spans out.
module tb_thick_line_rasterizer_unit;

   import tlr_pkg::*;

   localparam int GRID_MAX = 64;
   localparam int QUIET_LIMIT = 3000;
   localparam int ROUND_ITEMS = 75;

   typedef struct {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] centre_row;
      logic [COORD_W-1:0] span_low;
      logic [COORD_W-1:0] span_high;
      logic               visible;
      logic               last_column;
   } column_span_type;

   class span_scoreboard;
      column_span_type expected_spans[$];
      int unsigned grid_columns;
      int unsigned grid_rows;
      int errors;

      function new();
         grid_columns = 16;
         grid_rows = 16;
         errors = 0;
      endfunction

      function void write_grid(logic reg_index, logic [31:0] value);
         if (reg_index == REG_GRID_COLUMNS) begin
            grid_columns = value[REG_W-1:0];
         end else begin
            grid_rows = value[REG_W-1:0];
         end
      endfunction

      function int pending();
         return expected_spans.size();
      endfunction

      function void add_column(int x, int y, int t, bit last);
         column_span_type s;
         int cols;
         int rows;
         int lo;
         int hi;
         bit vis;
         cols = (grid_columns > GRID_MAX) ? GRID_MAX : grid_columns;
         rows = (grid_rows > GRID_MAX) ? GRID_MAX : grid_rows;
         lo = y - (t - 1);
         hi = y + (t - 1);
         if (lo < 0) lo = 0;
         if (rows == 0) begin
            hi = 0;
            vis = 1'b0;
         end else begin
            if (hi > rows - 1) hi = rows - 1;
            vis = (x < cols) && (lo <= hi);
         end
         s.column = x[COORD_W-1:0];
         s.centre_row = y[COORD_W-1:0];
         s.span_low = lo[COORD_W-1:0];
         s.span_high = hi[COORD_W-1:0];
         s.visible = vis;
         s.last_column = last;
         expected_spans.push_back(s);
      endfunction

      // Walks the segment with the midpoint decision and queues one span per column.
      function void note_segment(logic [COORD_W-1:0] fx, logic [COORD_W-1:0] fy,
                                 logic [COORD_W-1:0] sx, logic [COORD_W-1:0] sy,
                                 logic [THICK_W-1:0] th);
         int ax, ay, bx, by, t, dx, dy, sg, d, de, dd, x, y, n, tmp;
         ax = fx; ay = fy; bx = sx; by = sy; t = th;
         if (t == 0) t = 1;
         if (ax > bx) begin
            tmp = ax; ax = bx; bx = tmp;
            tmp = ay; ay = by; by = tmp;
         end
         dx = bx - ax;
         dy = by - ay;
         sg = (dx > 0 && dy < 0) ? -1 : 1;
         d = 2 * dy - dx * sg;
         de = 2 * dy;
         dd = 2 * (dy - dx * sg);
         x = ax;
         y = ay;
         add_column(x, y, t, x >= bx);
         n = 1;
         while (x < bx && n < GRID_MAX) begin
            if (d * sg <= 0) begin
               d += de;
            end else begin
               d += dd;
               y += sg;
            end
            x++;
            if (y < 0) y = 0;
            if (y > 63) y = 63;
            add_column(x, y, t, x >= bx);
            n++;
         end
      endfunction

      function void check_span(column_span_type got);
         column_span_type want;
         if (expected_spans.size() == 0) begin
            $error("unexpected span at column %0d", got.column);
            errors++;
            return;
         end
         want = expected_spans.pop_front();
         if (got.column !== want.column) begin
            $error("column: expected %0d, got %0d", want.column, got.column);
            errors++;
         end
         if (got.centre_row !== want.centre_row) begin
            $error("centre_row: expected %0d, got %0d", want.centre_row, got.centre_row);
            errors++;
         end
         if (got.span_low !== want.span_low) begin
            $error("span_low: expected %0d, got %0d", want.span_low, got.span_low);
            errors++;
         end
         if (got.span_high !== want.span_high) begin
            $error("span_high: expected %0d, got %0d", want.span_high, got.span_high);
            errors++;
         end
         if (got.visible !== want.visible) begin
            $error("visible: expected %0d, got %0d", want.visible, got.visible);
            errors++;
         end
         if (got.last_column !== want.last_column) begin
            $error("last_column: expected %0d, got %0d", want.last_column, got.last_column);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [COORD_W-1:0] req_first_x = '0;
   logic [COORD_W-1:0] req_first_y = '0;
   logic [COORD_W-1:0] req_second_x = '0;
   logic [COORD_W-1:0] req_second_y = '0;
   logic [THICK_W-1:0] req_thickness = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [COORD_W-1:0] rsp_column;
   logic [COORD_W-1:0] rsp_centre_row;
   logic [COORD_W-1:0] rsp_span_low;
   logic [COORD_W-1:0] rsp_span_high;
   logic               rsp_visible;
   logic               rsp_last_column;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;
   span_scoreboard sb;

   thick_line_rasterizer_unit #(.GRID_MAX(GRID_MAX)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_first_x(req_first_x),
      .req_first_y(req_first_y),
      .req_second_x(req_second_x),
      .req_second_y(req_second_y),
      .req_thickness(req_thickness),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_column(rsp_column),
      .rsp_centre_row(rsp_centre_row),
      .rsp_span_low(rsp_span_low),
      .rsp_span_high(rsp_span_high),
      .rsp_visible(rsp_visible),
      .rsp_last_column(rsp_last_column),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Both handshakes are sampled here, with the values that held just before the edge.
   always @(posedge clock) begin
      column_span_type got;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_segment(req_first_x, req_first_y, req_second_x, req_second_y,
                            req_thickness);
         end
         if (rsp_valid && !rsp_stall) begin
            got.column = rsp_column;
            got.centre_row = rsp_centre_row;
            got.span_low = rsp_span_low;
            got.span_high = rsp_span_high;
            got.visible = rsp_visible;
            got.last_column = rsp_last_column;
            sb.check_span(got);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic send_segment(input int fx, input int fy, input int sx, input int sy,
                               input int th);
      req_first_x <= fx[COORD_W-1:0];
      req_first_y <= fy[COORD_W-1:0];
      req_second_x <= sx[COORD_W-1:0];
      req_second_y <= sy[COORD_W-1:0];
      req_thickness <= th[THICK_W-1:0];
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // The first edge lets the monitor note a request taken at the edge just passed.
   task automatic drain_spans();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_index, input int value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_grid(reg_index, value);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_grid(input int cols, input int rows);
      drain_spans();
      csr_write(REG_GRID_COLUMNS, cols);
      csr_write(REG_GRID_ROWS, rows);
   endtask

   function automatic int pick_grid_value();
      case ($urandom_range(4))
         0: return 0;
         1: return 1;
         2: return GRID_MAX;
         3: return 127;
         default: return $urandom_range(1, 127);
      endcase
   endfunction

   initial begin
      int fx, fy, sx, sy;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default grid: long, reversed, vertical, single-point, steep and falling segments.
      send_segment(0, 0, 63, 0, 1);
      send_segment(63, 63, 0, 0, 15);
      send_segment(5, 10, 5, 40, 3);
      send_segment(5, 40, 5, 10, 3);
      send_segment(0, 0, 0, 0, 0);
      send_segment(2, 0, 4, 63, 2);
      send_segment(0, 63, 63, 0, 15);
      send_segment(10, 20, 50, 5, 4);
      send_segment(0, 50, 10, 60, 2);
      send_segment(63, 0, 63, 63, 15);

      set_grid(0, 0);
      send_segment(0, 5, 8, 9, 3);
      send_segment(3, 0, 3, 0, 1);
      set_grid(127, 127);
      send_segment(0, 0, 63, 63, 15);
      send_segment(60, 2, 63, 1, 8);
      send_segment(40, 63, 20, 62, 0);
      set_grid(1, 1);
      send_segment(0, 0, 3, 1, 2);
      send_segment(0, 1, 1, 0, 1);
      set_grid(GRID_MAX, GRID_MAX);
      send_segment(62, 60, 63, 63, 7);
      send_segment(0, 63, 5, 30, 15);

      for (int round = 0; round < 6; round++) begin
         set_grid(pick_grid_value(), pick_grid_value());
         case (round % 4)
            0: begin idle_pct <= 0; stall_pct <= 0; end
            1: begin idle_pct <= 78; stall_pct <= 0; end
            2: begin idle_pct <= 0; stall_pct <= 78; end
            default: begin idle_pct <= 9; stall_pct <= 9; end
         endcase
         for (int i = 0; i < ROUND_ITEMS; i++) begin
            if ($urandom_range(39) == 0) drain_spans();
            fx = $urandom_range(63);
            fy = $urandom_range(63);
            sy = $urandom_range(63);
            // Mostly short segments keep the run brief; the rest may end at any column of the grid.
            if ($urandom_range(9) < 7) begin
               sx = fx + $urandom_range(16) - 8;
               if (sx < 0) sx = 0;
               if (sx > 63) sx = 63;
            end else begin
               sx = $urandom_range(63);
            end
            send_segment(fx, fy, sx, sy, $urandom_range(15));
         end
      end

      drain_spans();
      repeat (GRID_MAX + 8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== thick_line_rasterizer_unit.f =====
src/tlr_pkg.sv
src/tlr_span.sv
src/thick_line_rasterizer_unit.sv
tb/tb_thick_line_rasterizer_unit.sv
